[rtl/tbrc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbrc_pkg
// shared types and constants of the table reply row counter
// ----------------------------------------------------------------------------
package tbrc_pkg;

    // scan phases, one-hot
    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_SEEK   = 6'b000010,
        PH_ROWS   = 6'b000100,
        PH_TNUM   = 6'b001000,
        PH_TSUF   = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

    // first-field parser phases, one-hot
    typedef enum logic [3:0] {
        FP_WS     = 4'b0001,
        FP_SIGN   = 4'b0010,
        FP_DIGITS = 4'b0100,
        FP_JUNK   = 4'b1000
    } t_fphase;

    // result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_RULE     = 2'd1;
    localparam logic [1:0] ST_BAD_TRAILER = 2'd2;
    localparam logic [1:0] ST_MISMATCH    = 2'd3;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_W     = 8'h77;

    // trailer suffix " rows." has this many characters
    localparam logic [2:0] SUFFIX_LEN = 3'd6;

    localparam logic [62:0] ID_LIMIT = {63{1'b1}};

    // control from the scanner to the field parser
    typedef struct packed {
        logic feed;   // byte belongs to the first field of the first row
        logic clear;  // reply finished, back to reset values
    } t_field_ctl;

    // parsed first field, as seen after the current byte
    typedef struct packed {
        logic        int_ok;    // well formed integer of legal length
        logic        negative;
        logic        fits;      // value plus one stays within 63 bits
        logic [62:0] value;
    } t_field_view;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // character of " rows." at position p
    function automatic logic [7:0] suffix_char(input logic [2:0] p);
        logic [7:0] c;
        unique case (p)
            3'd0:    c = CH_SPACE;
            3'd1:    c = CH_R;
            3'd2:    c = CH_O;
            3'd3:    c = CH_W;
            3'd4:    c = CH_S;
            3'd5:    c = CH_DOT;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/tbrc_field.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbrc_field
// parses the first tab-separated field of the first row as a signed integer
// ----------------------------------------------------------------------------
module tbrc_field #(
    parameter int FIELD_LIMIT = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [7:0]           i_byte,
    input  wire tbrc_pkg::t_field_ctl i_ctl,
    output tbrc_pkg::t_field_view     o_view
);
    import tbrc_pkg::*;

    localparam int LW = $clog2(FIELD_LIMIT + 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(FIELD_LIMIT);

    logic [LW-1:0] r_len, n_len, s_len;
    t_fphase       r_fp, n_fp, s_fp;
    logic          r_neg, n_neg, s_neg;
    logic          r_bad, n_bad, s_bad;
    logic [62:0]   r_val, n_val, s_val;
    logic [66:0]   prod;
    logic          take_digit;

    // value * 10 + digit
    assign prod = ({4'b0, r_val} << 3) + ({4'b0, r_val} << 1) + {63'b0, i_byte[3:0]};

    always_comb begin
        s_len      = r_len;
        s_fp       = r_fp;
        s_neg      = r_neg;
        s_bad      = r_bad;
        s_val      = r_val;
        take_digit = 1'b0;
        if (i_ctl.feed) begin
            if (r_len < LEN_MAX) begin
                s_len = r_len + LW'(1);
            end
            unique case (r_fp)
                FP_WS: begin
                    if (i_byte == CH_SPACE || i_byte == CH_VT ||
                        i_byte == CH_FF || i_byte == CH_CR) begin
                        s_fp = FP_WS;
                    end else if (i_byte == CH_PLUS || i_byte == CH_DASH) begin
                        s_neg = (i_byte == CH_DASH);
                        s_fp  = FP_SIGN;
                    end else if (is_digit(i_byte)) begin
                        s_fp       = FP_DIGITS;
                        take_digit = 1'b1;
                    end else begin
                        s_fp = FP_JUNK;
                    end
                end
                FP_SIGN, FP_DIGITS: begin
                    if (is_digit(i_byte)) begin
                        s_fp       = FP_DIGITS;
                        take_digit = 1'b1;
                    end else begin
                        s_fp = FP_JUNK;
                    end
                end
                default: s_fp = r_fp;
            endcase
            // once bad the value is never looked at again
            if (take_digit && !r_bad) begin
                s_val = prod[62:0];
                if (prod > {4'b0, ID_LIMIT}) begin
                    s_bad = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_view.int_ok   = (s_fp == FP_DIGITS) && (s_len != '0) && (s_len < LEN_MAX);
        o_view.negative = s_neg;
        o_view.fits     = !s_bad && (s_val < ID_LIMIT);
        o_view.value    = s_val;
    end

    always_comb begin
        if (i_ctl.clear) begin
            n_len = '0;
            n_fp  = FP_WS;
            n_neg = 1'b0;
            n_bad = 1'b0;
            n_val = '0;
        end else begin
            n_len = s_len;
            n_fp  = s_fp;
            n_neg = s_neg;
            n_bad = s_bad;
            n_val = s_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_fp  <= FP_WS;
            r_neg <= 1'b0;
            r_bad <= 1'b0;
            r_val <= '0;
        end else begin
            r_len <= n_len;
            r_fp  <= n_fp;
            r_neg <= n_neg;
            r_bad <= n_bad;
            r_val <= n_val;
        end
    end

endmodule
`default_nettype wire

[rtl/tbrc_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbrc_scan
// line scanner: header, rule, row count and trailer check
// ----------------------------------------------------------------------------
module tbrc_scan #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic                  i_eob,
    input  wire logic [7:0]            i_byte,
    output tbrc_pkg::t_field_ctl       o_fctl,
    output logic [1:0]                 o_status,
    output logic [COUNT_BITS:0]        o_rows
);
    import tbrc_pkg::*;

    localparam int CW = COUNT_BITS + 1;
    localparam logic [CW-1:0] CAP = CW'(1) << COUNT_BITS;

    t_phase         r_phase, n_phase, s_phase;
    logic           r_empty, n_empty, s_empty;
    logic           r_dash, n_dash, s_dash;
    logic [CW-1:0]  r_rows, n_rows, s_rows;
    logic [CW-1:0]  r_tval, n_tval, s_tval;
    logic [2:0]     r_tprog, n_tprog, s_tprog;
    logic           r_tdig, n_tdig, s_tdig;
    logic           r_fclosed, n_fclosed, s_fclosed;
    logic [1:0]     r_rstat, n_rstat, s_rstat;
    logic           r_ended, n_ended, s_ended;
    logic           consume;
    logic           is_lf;
    logic           clear;
    logic [CW+3:0]  tprod;
    logic [2:0]     tprog_inc;

    assign consume   = i_step && !r_ended && (i_byte != CH_NUL);
    assign is_lf     = (i_byte == CH_LF);
    assign clear     = i_step && i_eob;
    assign tprod     = ({4'b0, r_tval} << 3) + ({4'b0, r_tval} << 1)
                     + {{CW{1'b0}}, i_byte[3:0]};
    assign tprog_inc = r_tprog + 3'd1;

    always_comb begin
        s_phase   = r_phase;
        s_empty   = r_empty;
        s_dash    = r_dash;
        s_rows    = r_rows;
        s_tval    = r_tval;
        s_tprog   = r_tprog;
        s_tdig    = r_tdig;
        s_fclosed = r_fclosed;
        s_rstat   = r_rstat;
        s_ended   = r_ended || (i_step && (i_byte == CH_NUL));
        o_fctl.feed = 1'b0;
        if (consume) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (is_lf) begin
                        s_phase = PH_SEEK;
                        s_empty = 1'b1;
                        s_dash  = 1'b1;
                    end
                end
                PH_SEEK: begin
                    if (is_lf) begin
                        if (!r_empty && r_dash) begin
                            s_phase = PH_ROWS;
                        end
                        s_empty = 1'b1;
                        s_dash  = 1'b1;
                    end else begin
                        s_empty = 1'b0;
                        if (i_byte != CH_DASH) begin
                            s_dash = 1'b0;
                        end
                    end
                end
                PH_ROWS: begin
                    if (is_lf) begin
                        if (r_empty) begin
                            s_phase = PH_TNUM;
                            s_tval  = '0;
                            s_tdig  = 1'b0;
                        end else begin
                            s_fclosed = 1'b1;
                            if (r_rows < CAP) begin
                                s_rows = r_rows + CW'(1);
                            end
                        end
                        s_empty = 1'b1;
                        s_dash  = 1'b1;
                    end else begin
                        s_empty = 1'b0;
                        if (r_rows == '0 && !r_fclosed) begin
                            if (i_byte == CH_TAB) begin
                                s_fclosed = 1'b1;
                            end else begin
                                o_fctl.feed = 1'b1;
                            end
                        end
                    end
                end
                PH_TNUM: begin
                    if (is_digit(i_byte)) begin
                        // saturate at the cap, which flags overflow
                        s_tval = (tprod > {4'b0, CAP}) ? CAP : tprod[CW-1:0];
                        s_tdig = 1'b1;
                    end else if (i_byte == CH_SPACE && !r_tdig) begin
                        s_tdig = 1'b0;
                    end else if (i_byte == CH_SPACE) begin
                        s_phase = PH_TSUF;
                        s_tprog = 3'd1;
                    end else begin
                        s_phase = PH_DONE;
                        s_rstat = ST_BAD_TRAILER;
                    end
                end
                PH_TSUF: begin
                    if (i_byte == suffix_char(r_tprog)) begin
                        s_tprog = tprog_inc;
                        if (tprog_inc >= SUFFIX_LEN) begin
                            s_phase = PH_DONE;
                            s_rstat = (r_rows >= CAP || r_tval >= CAP ||
                                       r_rows != r_tval) ? ST_MISMATCH : ST_OK;
                        end
                    end else begin
                        s_phase = PH_DONE;
                        s_rstat = ST_BAD_TRAILER;
                    end
                end
                default: s_phase = r_phase;
            endcase
        end
        o_fctl.clear = clear;
    end

    // status as if the reply ended after this byte
    always_comb begin
        unique case (s_phase)
            PH_HEADER: o_status = ST_NO_RULE;
            PH_SEEK:   o_status = (!s_empty && s_dash) ? ST_BAD_TRAILER : ST_NO_RULE;
            PH_DONE:   o_status = s_rstat;
            default:   o_status = ST_BAD_TRAILER;
        endcase
    end

    assign o_rows = s_rows;

    always_comb begin
        if (clear) begin
            n_phase   = PH_HEADER;
            n_empty   = 1'b1;
            n_dash    = 1'b1;
            n_rows    = '0;
            n_tval    = '0;
            n_tprog   = '0;
            n_tdig    = 1'b0;
            n_fclosed = 1'b0;
            n_rstat   = ST_OK;
            n_ended   = 1'b0;
        end else begin
            n_phase   = s_phase;
            n_empty   = s_empty;
            n_dash    = s_dash;
            n_rows    = s_rows;
            n_tval    = s_tval;
            n_tprog   = s_tprog;
            n_tdig    = s_tdig;
            n_fclosed = s_fclosed;
            n_rstat   = s_rstat;
            n_ended   = s_ended;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_empty   <= 1'b1;
            r_dash    <= 1'b1;
            r_rows    <= '0;
            r_tval    <= '0;
            r_tprog   <= '0;
            r_tdig    <= 1'b0;
            r_fclosed <= 1'b0;
            r_rstat   <= ST_OK;
            r_ended   <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_empty   <= n_empty;
            r_dash    <= n_dash;
            r_rows    <= n_rows;
            r_tval    <= n_tval;
            r_tprog   <= n_tprog;
            r_tdig    <= n_tdig;
            r_fclosed <= n_fclosed;
            r_rstat   <= n_rstat;
            r_ended   <= n_ended;
        end
    end

endmodule
`default_nettype wire

[rtl/table_reply_row_counter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// table_reply_row_counter_unit
// checks a byte-wide text reply for a table and reports row count and next id
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | word
//  ---------+--------------------+----------------------------------------------
//  input    | i_valid / o_stall  | i_data_byte, i_end_of_body
//  output   | o_valid / i_stall  | o_status, o_row_count, o_next_id, o_id_error
//
//  one byte per cycle while o_stall is low; a byte waits in the input register
//  and is folded into the scan state at the edge that loads the result register,
//  so a result is registered as its end_of_body byte leaves the input register
//  ordinary bytes keep flowing while a result waits; only an end_of_body byte
//  held while the result register is full and stalled stalls the input
//  synchronous active-low reset clears all control state and the scan
//  ----------------------------------------------------------------------------
module table_reply_row_counter_unit #(
    parameter int COUNT_BITS  = 16,
    parameter int FIELD_LIMIT = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_body,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_row_count,
    output logic [62:0]      o_next_id,
    output logic             o_id_error
);
    import tbrc_pkg::*;

    localparam int CW = COUNT_BITS + 1;

    // input register
    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eob;

    // result register
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_status;
    logic [15:0] r_count;
    logic [62:0] r_id;
    logic        r_err;

    logic              accept;
    logic              advance;
    logic              emit;
    t_field_ctl        fctl;
    t_field_view       fview;
    logic [1:0]        scan_status;
    logic [CW-1:0]     rows;
    logic [CW+15:0]    rows_wide;
    logic [15:0]       res_count;
    logic [62:0]       res_id;
    logic              res_err;

    // the held byte moves on unless it ends a reply and the result slot is blocked
    assign advance = r_in_valid && (!r_in_eob || !r_out_valid || !i_stall);
    assign emit    = advance && r_in_eob;
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_eob  <= i_end_of_body;
        end
    end

    tbrc_scan #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_eob    (r_in_eob),
        .i_byte   (r_in_byte),
        .o_fctl   (fctl),
        .o_status (scan_status),
        .o_rows   (rows)
    );

    tbrc_field #(
        .FIELD_LIMIT (FIELD_LIMIT)
    ) u_field (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (r_in_byte),
        .i_ctl   (fctl),
        .o_view  (fview)
    );

    // low 16 bits of the row count, whatever the counter width
    assign rows_wide = {16'b0, rows};

    // result word from the state as it stands after the last byte
    always_comb begin
        res_count = '0;
        res_id    = '0;
        res_err   = 1'b1;
        if (scan_status == ST_OK) begin
            res_count = rows_wide[15:0];
            if (rows == '0) begin
                // no rows: ids start at one
                res_id  = 63'd1;
                res_err = 1'b0;
            end else if (fview.int_ok) begin
                if (fview.negative) begin
                    res_id  = 63'd1;
                    res_err = 1'b0;
                end else if (fview.fits) begin
                    res_id  = fview.value + 63'd1;
                    res_err = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= scan_status;
            r_count  <= res_count;
            r_id     <= res_id;
            r_err    <= res_err;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_row_count = r_count;
    assign o_next_id   = r_id;
    assign o_id_error  = r_err;

endmodule
`default_nettype wire

[verif/tb_table_reply_row_counter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_table_reply_row_counter_unit
// self-checking bench for the table reply row counter
// ----------------------------------------------------------------------------
// replies are fed one byte word at a time and a cycle-free scan model predicts
// status, row count, next id and id error for every end-of-body word
// stimulus: directed replies for each error path, then well-formed tables
// with random content mixed with noise, cut-off and corrupted replies, under
// four sender/receiver idle mixes and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb_table_reply_row_counter_unit;
    import tbrc_pkg::*;

    localparam int          COUNT_BITS   = 16;
    localparam int          FIELD_LIMIT  = 32;
    localparam int unsigned ROW_CAP      = 1 << COUNT_BITS;
    localparam logic [63:0] ID_TOP       = 64'h7FFF_FFFF_FFFF_FFFF;
    // largest value that can take one more decimal digit without 64-bit wrap
    localparam logic [63:0] ACC_GUARD    = (64'hFFFF_FFFF_FFFF_FFFF - 64'd9) / 64'd10;
    localparam logic [47:0] SUFFIX       = " rows.";
    localparam logic [31:0] WS_SET       = {CH_SPACE, CH_VT, CH_FF, CH_CR};
    localparam int          CLK_PERIOD   = 20;
    localparam int          SLICE_WORDS  = 390;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          RUN_LIMIT_NS = 30_000_000;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    // one input word
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_text_word;

    // one result word
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] rows;
        logic [62:0] next_id;
        logic        id_err;
    } t_table_reply;

    // dut ports, all inputs known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_data_byte   = '0;
    logic        i_end_of_body = 1'b0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_row_count;
    logic [62:0] o_next_id;
    logic        o_id_error;

    // bench control
    t_idle_mode   idle_mode = IDLE_NONE;
    logic         hold_go   = 1'b0;
    logic         hold_on   = 1'b0;
    int           n_fail    = 0;
    int           words_sent = 0;
    t_text_word   text_words[$];
    t_table_reply expected_replies[$];
    logic [7:0]   txt[$];

    // scan model state
    t_phase      sc_phase;
    logic        ln_empty;
    logic        ln_dash;
    int unsigned rows_seen;
    int unsigned tr_value;
    int          tr_pos;
    logic        tr_digits;
    int          fd_len;
    t_fphase     fd_phase;
    logic        fd_neg;
    logic [63:0] fd_value;
    logic        fd_bad;
    logic        fd_closed;
    logic [1:0]  sc_status;
    logic        txt_ended;

    table_reply_row_counter_unit #(
        .COUNT_BITS  (COUNT_BITS),
        .FIELD_LIMIT (FIELD_LIMIT)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_end_of_body (i_end_of_body),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_row_count   (o_row_count),
        .o_next_id     (o_next_id),
        .o_id_error    (o_id_error)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // scan model
    // ------------------------------------------------------------------

    function automatic logic is_num(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    task automatic scan_reset();
        sc_phase  = PH_HEADER;
        ln_empty  = 1'b1;
        ln_dash   = 1'b1;
        rows_seen = 0;
        tr_value  = 0;
        tr_pos    = 0;
        tr_digits = 1'b0;
        fd_len    = 0;
        fd_phase  = FP_WS;
        fd_neg    = 1'b0;
        fd_value  = '0;
        fd_bad    = 1'b0;
        fd_closed = 1'b0;
        sc_status = ST_OK;
        txt_ended = 1'b0;
    endtask

    task automatic scan_decide(input logic [1:0] s);
        sc_status = s;
        sc_phase  = PH_DONE;
    endtask

    // decimal accumulation of the first field, sticky once out of range
    task automatic field_digit(input logic [7:0] b);
        if (!fd_bad) begin
            if (fd_value > ACC_GUARD) begin
                fd_bad = 1'b1;
            end else begin
                fd_value = fd_value * 64'd10 + (b - CH_ZERO);
                if (fd_value > ID_TOP)
                    fd_bad = 1'b1;
            end
        end
    endtask

    // strtoll-like walk: blanks, optional sign, digits, anything else is junk
    task automatic field_char(input logic [7:0] b);
        if (fd_len < FIELD_LIMIT)
            fd_len++;
        case (fd_phase)
            FP_WS: begin
                if (b == CH_PLUS || b == CH_DASH) begin
                    fd_neg   = (b == CH_DASH);
                    fd_phase = FP_SIGN;
                end else if (is_num(b)) begin
                    fd_phase = FP_DIGITS;
                    field_digit(b);
                end else if (!(b == CH_SPACE || b == CH_VT || b == CH_FF || b == CH_CR)) begin
                    fd_phase = FP_JUNK;
                end
            end
            FP_SIGN, FP_DIGITS: begin
                if (is_num(b)) begin
                    fd_phase = FP_DIGITS;
                    field_digit(b);
                end else begin
                    fd_phase = FP_JUNK;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic scan_char(input logic [7:0] b);
        logic [63:0] v;
        case (sc_phase)
            PH_HEADER: begin
                if (b == CH_LF) begin
                    sc_phase = PH_SEEK;
                    ln_empty = 1'b1;
                    ln_dash  = 1'b1;
                end
            end
            // looking for a non-empty all-dash line
            PH_SEEK: begin
                if (b == CH_LF) begin
                    if (!ln_empty && ln_dash)
                        sc_phase = PH_ROWS;
                    ln_empty = 1'b1;
                    ln_dash  = 1'b1;
                end else begin
                    ln_empty = 1'b0;
                    if (b != CH_DASH)
                        ln_dash = 1'b0;
                end
            end
            // rows until a blank line, first field of first row parsed
            PH_ROWS: begin
                if (b == CH_LF) begin
                    if (ln_empty) begin
                        sc_phase  = PH_TNUM;
                        tr_value  = 0;
                        tr_digits = 1'b0;
                    end else begin
                        fd_closed = 1'b1;
                        if (rows_seen < ROW_CAP)
                            rows_seen++;
                    end
                    ln_empty = 1'b1;
                    ln_dash  = 1'b1;
                end else begin
                    ln_empty = 1'b0;
                    if (rows_seen == 0 && !fd_closed) begin
                        if (b == CH_TAB)
                            fd_closed = 1'b1;
                        else
                            field_char(b);
                    end
                end
            end
            // trailer count, saturating at the row cap
            PH_TNUM: begin
                if (is_num(b)) begin
                    v = tr_value * 64'd10 + (b - CH_ZERO);
                    tr_value  = (v > ROW_CAP) ? ROW_CAP : 32'(v);
                    tr_digits = 1'b1;
                end else if (b == CH_SPACE && tr_digits) begin
                    sc_phase = PH_TSUF;
                    tr_pos   = 1;
                end else if (b != CH_SPACE) begin
                    scan_decide(ST_BAD_TRAILER);
                end
            end
            PH_TSUF: begin
                if (b == SUFFIX[8 * (5 - tr_pos) +: 8]) begin
                    tr_pos++;
                    if (tr_pos >= 6) begin
                        if (rows_seen >= ROW_CAP || tr_value >= ROW_CAP ||
                            rows_seen != tr_value)
                            scan_decide(ST_MISMATCH);
                        else
                            scan_decide(ST_OK);
                    end
                end else begin
                    scan_decide(ST_BAD_TRAILER);
                end
            end
            default: begin
            end
        endcase
    endtask

    // takes one accepted word, queues the reply due on end of body
    task automatic scan_word(input logic [7:0] b, input logic last);
        t_table_reply r;
        logic [63:0]  id;
        if (!txt_ended) begin
            if (b == CH_NUL)
                txt_ended = 1'b1;
            else
                scan_char(b);
        end
        if (last) begin
            case (sc_phase)
                PH_HEADER: r.status = ST_NO_RULE;
                PH_SEEK:   r.status = (!ln_empty && ln_dash) ? ST_BAD_TRAILER : ST_NO_RULE;
                PH_DONE:   r.status = sc_status;
                default:   r.status = ST_BAD_TRAILER;
            endcase
            r.rows   = '0;
            r.id_err = 1'b1;
            id       = '0;
            if (r.status == ST_OK) begin
                r.rows = 16'(rows_seen);
                if (rows_seen == 0) begin
                    id       = 64'd1;
                    r.id_err = 1'b0;
                end else if (fd_phase == FP_DIGITS && fd_len >= 1 && fd_len < FIELD_LIMIT) begin
                    if (fd_neg) begin
                        id       = 64'd1;
                        r.id_err = 1'b0;
                    end else if (!fd_bad && fd_value < ID_TOP) begin
                        id       = fd_value + 64'd1;
                        r.id_err = 1'b0;
                    end
                end
            end
            r.next_id = id[62:0];
            expected_replies.push_back(r);
            scan_reset();
        end
    endtask

    // ------------------------------------------------------------------
    // driver and monitor
    // ------------------------------------------------------------------

    function automatic int idle_pct(input logic sender_side);
        case (idle_mode)
            IDLE_SEND: return sender_side ? 60 : 0;
            IDLE_RECV: return sender_side ? 0 : 60;
            IDLE_BOTH: return 12;
            default:   return 0;
        endcase
    endfunction

    // input side: a stalled word is held, otherwise the next one is offered
    // unless the sender takes a gap this cycle
    always @(posedge i_clk) begin
        logic       nxt_v;
        t_text_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nxt_v = i_valid;
            if (i_valid && !o_stall) begin
                scan_word(i_data_byte, i_end_of_body);
                nxt_v = 1'b0;
            end
            if (!nxt_v && text_words.size() != 0 &&
                $urandom_range(0, 99) >= idle_pct(1'b1)) begin
                w = text_words.pop_front();
                i_data_byte   <= w.data;
                i_end_of_body <= w.last;
                nxt_v = 1'b1;
            end
            i_valid <= nxt_v;
        end
    end

    task automatic log_fail(input string what);
        n_fail++;
        if (n_fail <= 10)
            $display("%0t ns: %s", $time, what);
    endtask

    // output side: check each taken result word against the oldest prediction
    always @(posedge i_clk) begin
        t_table_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_replies.size() == 0) begin
                log_fail($sformatf("unexpected result word: status %0d rows %0d id %0d err %0d",
                                   o_status, o_row_count, o_next_id, o_id_error));
            end else begin
                want = expected_replies.pop_front();
                if (o_status !== want.status)
                    log_fail($sformatf("status mismatch: expected %0d, got %0d",
                                       want.status, o_status));
                if (o_row_count !== want.rows)
                    log_fail($sformatf("row count mismatch: expected %0d, got %0d",
                                       want.rows, o_row_count));
                if (o_next_id !== want.next_id)
                    log_fail($sformatf("next id mismatch: expected %0d, got %0d",
                                       want.next_id, o_next_id));
                if (o_id_error !== want.id_err)
                    log_fail($sformatf("id error mismatch: expected %0d, got %0d",
                                       want.id_err, o_id_error));
            end
        end
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= hold_on || ($urandom_range(0, 99) < idle_pct(1'b0));
    end

    // long receiver hold-off, counted here while the sender keeps offering,
    // so a second end of body backs up against the full result register
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // ------------------------------------------------------------------
    // reply builders
    // ------------------------------------------------------------------

    task automatic add_b(input logic [7:0] b);
        txt.push_back(b);
    endtask

    task automatic add_s(input string s);
        for (int k = 0; k < s.len(); k++)
            txt.push_back(s[k]);
    endtask

    // any byte that neither ends the text nor ends a line
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_LF);
        return c;
    endfunction

    task automatic add_digits(input int n);
        repeat (n) add_b(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // moves the built reply to the send queue, end of body on its last word
    task automatic send_reply();
        logic       live;
        t_text_word w;
        live = 1'b1;
        for (int k = 0; k < txt.size(); k++) begin
            w.data = txt[k];
            w.last = (k == txt.size() - 1);
            // words after a nul are dropped by the block, not counted
            if (live)
                words_sent++;
            if (txt[k] == CH_NUL)
                live = 1'b0;
            text_words.push_back(w);
        end
        txt.delete();
    endtask

    // first field of the first row, biased toward parser corners
    task automatic add_first_field();
        case ($urandom_range(0, 9))
            0: add_digits($urandom_range(1, 5));
            1: begin
                repeat ($urandom_range(1, 3)) add_b(WS_SET[8 * $urandom_range(0, 3) +: 8]);
                if ($urandom_range(0, 1))
                    add_b($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
                add_digits($urandom_range(1, 6));
            end
            2: add_digits($urandom_range(15, 19));
            3: add_s("9223372036854775806");
            4: add_s("9223372036854775807");
            5: begin
                add_b(CH_DASH);
                add_digits($urandom_range(20, 29));
            end
            6: add_b($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
            7: begin
                add_digits($urandom_range(1, 3));
                add_b(text_char());
            end
            // lengths 30 to 34 around the field length limit
            8: begin
                repeat ($urandom_range(29, 33)) add_b(CH_ZERO);
                add_b(CH_ZERO + 8'd7);
            end
            default: begin
                if ($urandom_range(0, 1))
                    add_s("20000000000000000000");
            end
        endcase
    endtask

    // header, optional stray lines, rule, rows, blank, trailer; then maybe
    // cut short, corrupted, ended by nul or followed by extra text
    task automatic add_table_reply();
        int n_rows;
        int n_said;
        repeat ($urandom_range(0, 6)) add_b(text_char());
        add_b(CH_LF);
        repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(0, 4))
                add_b($urandom_range(0, 2) == 0 ? CH_DASH : text_char());
            add_b(CH_LF);
        end
        repeat ($urandom_range(1, 5)) add_b(CH_DASH);
        add_b(CH_LF);
        n_rows = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
        for (int r = 0; r < n_rows; r++) begin
            if (r == 0) begin
                add_first_field();
                if ($urandom_range(0, 1)) begin
                    add_b(CH_TAB);
                    repeat ($urandom_range(0, 4)) add_b(text_char());
                end
            end else begin
                repeat ($urandom_range(1, 6)) add_b(text_char());
            end
            add_b(CH_LF);
        end
        add_b(CH_LF);
        repeat ($urandom_range(0, 2)) add_b(CH_SPACE);
        case ($urandom_range(0, 9))
            0:       n_said = n_rows + 1;
            1:       n_said = (n_rows == 0) ? 0 : n_rows - 1;
            2:       n_said = $urandom_range(65530, 70000);
            default: n_said = n_rows;
        endcase
        if ($urandom_range(0, 5) == 0)
            add_b(CH_ZERO);
        add_s($sformatf("%0d rows.", n_said));
        case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, txt.size() - 1)) txt.delete(txt.size() - 1);
            1: begin
                add_b(CH_NUL);
                repeat ($urandom_range(0, 3)) add_b(text_char());
            end
            2: repeat ($urandom_range(1, 4)) add_b(text_char());
            3: txt[txt.size() - 1 - $urandom_range(0, 5)] = text_char();
            default: begin
            end
        endcase
        send_reply();
    endtask

    // short byte soup rich in the characters the scanner cares about
    task automatic add_noise_reply();
        string pool;
        pool = "\n\n\n--- 0123456789 rows.+\t";
        repeat ($urandom_range(1, 30)) begin
            case ($urandom_range(0, 19))
                0:       add_b(CH_NUL);
                1, 2, 3: add_b(text_char());
                default: add_b(pool[$urandom_range(0, pool.len() - 1)]);
            endcase
        end
        send_reply();
    endtask

    task automatic drain();
        while (text_words.size() != 0 || i_valid || expected_replies.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial begin
        int target;
        scan_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed replies
        add_s("id\tname\n---\n1\tx\n2\ty\n\n2 rows.");      send_reply();
        add_s("h\n--\n\n 0 rows.");                          send_reply();
        add_b(CH_NUL);                                       send_reply(); // no text at all
        add_s("header only");                                send_reply(); // header not ended
        add_s("h\nabc\n\n");                                 send_reply(); // no rule
        add_s("h\nx\n---");                                  send_reply(); // rule not ended
        add_s("h\n-\nx\n\n3 rows.");                         send_reply(); // count mismatch
        add_s("h\n-\nx\n\n99999 rows.");                     send_reply(); // count overflow
        add_s("h\n-\nx\n\n1 rows");                          send_reply(); // cut off
        add_s("h\n-\nx\n\nrows.");                           send_reply(); // no digits
        add_s("h\n-\nx\n\n1 rowz.");                         send_reply(); // bad suffix
        add_s("h\n-\n  -5\tneg\n\n1 rows.tail");             send_reply(); // negative id
        add_s("h\n-\n9223372036854775806\n\n1 rows.");       send_reply(); // largest id
        add_s("h\n-\n9223372036854775807\n\n1 rows.");       send_reply(); // id overflow
        add_s("h\n-\n12a\tb\n\n1 rows.");                    send_reply(); // junk field
        add_s("h\n-\n\tb\n\n1 rows.");                       send_reply(); // empty field
        add_s("h\n-\n+12\tq\n\n1 rows.");
        add_b(CH_NUL);
        add_s("junk\n");                                     send_reply(); // ignored tail
        add_s("h\n-\n");
        add_b(CH_VT);
        add_b(CH_FF);
        add_b(CH_CR);
        add_s("7\n\n1 rows.");                               send_reply(); // vt, ff and cr blanks
        add_b(8'hFF);
        add_b(8'h80);
        add_s("\n-\n");
        add_b(8'h7F);
        add_s("\n\n1 rows.");
        add_b(CH_NUL);                                       send_reply(); // end on nul word
        drain();

        // random replies under each idle mix
        for (int m = 0; m < 4; m++) begin
            idle_mode = t_idle_mode'(m);
            if (idle_mode == IDLE_NONE)
                hold_go = 1'b1;
            target = words_sent + SLICE_WORDS;
            while (words_sent < target) begin
                if ($urandom_range(0, 3) == 0)
                    add_noise_reply();
                else
                    add_table_reply();
            end
            drain();
        end

        // catch stray result words
        repeat (20) @(negedge i_clk);
        if (n_fail == 0)
            $display("table_reply_row_counter_unit regression: pass");
        else
            $display("table_reply_row_counter_unit regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("table_reply_row_counter_unit regression: fail");
        $finish;
    end

endmodule
